>>> hdl/block_sum_downsampler_assert.svh
// assertion macros for the block sum downsampler
`ifndef BLOCK_SUM_DOWNSAMPLER_ASSERT_SVH
`define BLOCK_SUM_DOWNSAMPLER_ASSERT_SVH

`ifndef ASSERT_OFF

`define BSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bsd assertion failed");

`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bsd assertion failed");

`else

`define BSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/bsd_pkg.sv
`default_nettype none

package bsd_pkg;

    localparam int MAX_PIXEL  = 64;
    localparam int NUM_LAYERS = 6;
    localparam int NUM_CFG    = 6;

    localparam int PIX_W    = $clog2(MAX_PIXEL);
    localparam int LAYER_W  = 3;
    localparam int LG_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int E_W      = 24;
    localparam int SUM_W    = 36;
    localparam int NUM_COLS = 64;
    localparam int COL_W    = $clog2(NUM_COLS);

    localparam logic [LG_W-1:0] LG_MAX = LG_W'(PIX_W);

    localparam int IN_DATA_W  = 3 * E_W;
    localparam int OUT_DATA_W = 2 * PIX_W + 3 * SUM_W;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] charged;
        logic [SUM_W-1:0] neutral;
    } t_sums;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } t_mem_ctl;

    function automatic logic [SUM_W-1:0] sext_energy(input logic [E_W-1:0] e);
        return {{(SUM_W - E_W){e[E_W-1]}}, e};
    endfunction

endpackage

`default_nettype wire

>>> hdl/bsd_colmem.sv
`default_nettype none

module bsd_colmem (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  bsd_pkg::t_mem_ctl      i_ctl,
    input  bsd_pkg::t_sums         i_wr_data,
    output bsd_pkg::t_sums         o_rd_data
);

    bsd_pkg::t_sums                 r_mem [bsd_pkg::NUM_COLS];
    logic [bsd_pkg::NUM_COLS-1:0]   r_vld;
    bsd_pkg::t_sums                 r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_ctl.wr_addr] <= 1'b1;
        end
    end

    // forward a write to the same column in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            if (i_ctl.wr_en && (i_ctl.wr_addr == i_ctl.rd_addr)) begin
                r_rd <= i_wr_data;
            end else if (r_vld[i_ctl.rd_addr]) begin
                r_rd <= r_mem[i_ctl.rd_addr];
            end else begin
                r_rd <= '0;
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

>>> hdl/block_sum_downsampler.sv
// channel   dir  tdata (low bit up)                            tuser        tlast
// s_axis    in   total_energy, charged_energy, neutral_energy  layer_index  -
// m_axis    out  cell_row, cell_col, total_sum, charged_sum,   out_layer    last_cell
//                neutral_sum
// cfg       in   i_cfg_idx selects cells_log2_layer0..5, written when i_cfg_we is high
//
// one pixel per cycle while s_axis_tready is high; a cell leaves once its last pixel
// is taken, through the column sum read, then the add into the output register
// the column sum read and write back share one cycle through write forwarding
// synchronous reset: raster position zero, all column sums read as zero,
// registers back to six
// s_axis_tready drops only while an emitting item waits behind a full output
`default_nettype none
`include "block_sum_downsampler_assert.svh"

module block_sum_downsampler (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // total_energy, charged_energy, neutral_energy
    input  wire  [bsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // layer_index
    input  wire  [bsd_pkg::LAYER_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // cell_row, cell_col, total_sum, charged_sum, neutral_sum
    output logic [bsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // out_layer
    output logic [bsd_pkg::LAYER_W-1:0]        m_axis_tuser,
    output logic                               m_axis_tlast,
    input  wire                                i_cfg_we,
    input  wire  [bsd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [bsd_pkg::LG_W-1:0]           i_cfg_data
);

    localparam int PW = bsd_pkg::PIX_W;
    localparam int CW = bsd_pkg::COL_W;
    localparam int EW = bsd_pkg::E_W;

    logic [bsd_pkg::LG_W-1:0]    r_cfg [bsd_pkg::NUM_CFG];
    logic [PW-1:0]               r_row;
    logic [PW-1:0]               r_col;

    logic                        r_s1_vld;
    logic [bsd_pkg::LAYER_W-1:0] r_s1_layer;
    logic [PW-1:0]               r_s1_crow;
    logic [CW-1:0]               r_s1_ccol;
    logic                        r_s1_clr;
    logic                        r_s1_emit;
    logic                        r_s1_last;
    logic [EW-1:0]               r_s1_te;
    logic [EW-1:0]               r_s1_ce;
    logic [EW-1:0]               r_s1_ne;

    logic                        r_o_vld;
    logic [bsd_pkg::LAYER_W-1:0] r_o_layer;
    logic [PW-1:0]               r_o_crow;
    logic [PW-1:0]               r_o_ccol;
    logic                        r_o_last;
    bsd_pkg::t_sums              r_o_sums;

    logic                        w_accept;
    logic                        w_in_range;
    logic                        w_s1_move;
    logic [bsd_pkg::LG_W-1:0]    w_lg;
    logic [bsd_pkg::LG_W-1:0]    w_sh;
    logic [PW-1:0]               w_mask;
    logic [PW:0]                 w_n_m1;
    logic [PW-1:0]               w_crow;
    logic [PW-1:0]               w_ccol;
    logic [PW-1:0]               w_rrow;
    logic [PW-1:0]               w_rcol;
    logic [bsd_pkg::LAYER_W-1:0] w_layer;
    bsd_pkg::t_sums              w_acc;
    bsd_pkg::t_sums              w_base;
    bsd_pkg::t_sums              w_sum;
    bsd_pkg::t_mem_ctl           w_ctl;

    assign w_layer    = s_axis_tuser;
    assign w_in_range = 32'(w_layer) < bsd_pkg::NUM_LAYERS;
    assign w_s1_move  = r_s1_vld && (!r_s1_emit || !r_o_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || w_s1_move;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // register lookup, values above the top saturate
    always_comb begin
        w_lg = bsd_pkg::LG_MAX;
        for (int i = 0; i < bsd_pkg::NUM_CFG; i++) begin
            if (32'(w_layer) == i) begin
                w_lg = r_cfg[i];
            end
        end
        if (w_lg > bsd_pkg::LG_MAX) begin
            w_lg = bsd_pkg::LG_MAX;
        end
    end

    assign w_sh   = bsd_pkg::LG_MAX - w_lg;
    assign w_mask = PW'(((PW+1)'(1) << w_sh) - (PW+1)'(1));
    assign w_n_m1 = ((PW+1)'(1) << w_lg) - (PW+1)'(1);
    assign w_crow = r_row >> w_sh;
    assign w_ccol = r_col >> w_sh;
    assign w_rrow = r_row & w_mask;
    assign w_rcol = r_col & w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bsd_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= bsd_pkg::LG_MAX;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < bsd_pkg::NUM_CFG; i++) begin
                if (32'(i_cfg_idx) == i) begin
                    r_cfg[i] <= i_cfg_data;
                end
            end
        end
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (32'(r_col) == bsd_pkg::MAX_PIXEL - 1) begin
                r_col <= '0;
                r_row <= (32'(r_row) == bsd_pkg::MAX_PIXEL - 1) ? '0 : r_row + PW'(1);
            end else begin
                r_col <= r_col + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= w_in_range;
        end else if (w_s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_layer <= w_layer;
            r_s1_crow  <= w_crow;
            r_s1_ccol  <= CW'(w_ccol);
            r_s1_clr   <= (w_rrow == '0) && (w_rcol == '0);
            r_s1_emit  <= (w_rrow == w_mask) && (w_rcol == w_mask);
            r_s1_last  <= ({1'b0, w_crow} == w_n_m1) && ({1'b0, w_ccol} == w_n_m1);
            r_s1_te    <= s_axis_tdata[EW-1:0];
            r_s1_ce    <= s_axis_tdata[2*EW-1:EW];
            r_s1_ne    <= s_axis_tdata[3*EW-1:2*EW];
        end
    end

    assign w_ctl.rd_en   = w_accept && w_in_range;
    assign w_ctl.rd_addr = CW'(w_ccol);
    assign w_ctl.wr_en   = w_s1_move;
    assign w_ctl.wr_addr = r_s1_ccol;

    bsd_colmem u_colmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_data (w_sum),
        .o_rd_data (w_acc)
    );

    // first pixel of a block starts from zero
    assign w_base        = r_s1_clr ? '0 : w_acc;
    assign w_sum.total   = w_base.total   + bsd_pkg::sext_energy(r_s1_te);
    assign w_sum.charged = w_base.charged + bsd_pkg::sext_energy(r_s1_ce);
    assign w_sum.neutral = w_base.neutral + bsd_pkg::sext_energy(r_s1_ne);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_s1_move && r_s1_emit) begin
            r_o_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move && r_s1_emit) begin
            r_o_layer <= r_s1_layer;
            r_o_crow  <= r_s1_crow;
            r_o_ccol  <= PW'(r_s1_ccol);
            r_o_last  <= r_s1_last;
            r_o_sums  <= w_sum;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_layer;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {r_o_sums.neutral, r_o_sums.charged, r_o_sums.total,
                            r_o_ccol, r_o_crow};

    `BSD_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, r_s1_vld && r_s1_emit && r_o_vld)
    `BSD_ASSERT_IMP(a_free_out_moves, i_clk, i_rst_n, r_s1_vld && !r_o_vld, w_s1_move)
    `BSD_ASSERT_IMP(a_last_diag, i_clk, i_rst_n, r_o_vld && r_o_last, r_o_crow == r_o_ccol)
    `BSD_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n, w_s1_move && r_s1_emit, r_o_vld)

endmodule

`default_nettype wire
